/* rtl/integral_and_square_integral_image_defines.svh */
// Assertion macros for the integral image block
`ifndef INTEGRAL_AND_SQUARE_INTEGRAL_IMAGE_DEFINES_SVH
`define INTEGRAL_AND_SQUARE_INTEGRAL_IMAGE_DEFINES_SVH
`ifndef SYNTHESIS
`define IAS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define IAS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IAS_ASSERT_IMP(label, clk, rst, ante, cons)
`define IAS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/ias_pkg.sv */
// Types and constants for the integral image block
package ias_pkg;
   localparam int PIX_W      = 8;
   localparam int PIX_SQ_W   = 16;
   localparam int COL_SUM_W  = 18;
   localparam int COL_SQ_W   = 26;
   localparam int INT_W      = 28;
   localparam int SQ_STATE_W = 37;
   localparam int SQ_OUT_W   = 36;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int STORE_W    = COL_SUM_W + COL_SQ_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;
endpackage

/* rtl/integral_and_square_integral_image.sv */
// Stage 1 holds each accepted pixel; its result is registered as stage 1 advances.
// Throughput: one pixel per cycle while results are taken; the line store does a
// read-modify-write per column, forwarding if consecutive pixels hit one column.
// Reset: synchronous; clears position, left sums and handshake state and sets
// frame width and height to 1024. Line store contents are not cleared.
// Top level of the integral and squared integral image block
`include "integral_and_square_integral_image_defines.svh"
module integral_and_square_integral_image #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ias_pkg::PIX_W-1:0]        req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ias_pkg::INT_W-1:0]        rsp_integral_sum,
   output logic [ias_pkg::SQ_OUT_W-1:0]     rsp_square_sum,
   output logic                             rsp_frame_end,
   input  logic                             csr_write_enable,
   input  logic [ias_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ias_pkg::CFG_W-1:0]        csr_wdata
);
   localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCmpW = ($clog2(MAX_WIDTH + 1) > ias_pkg::CFG_W) ?
                          $clog2(MAX_WIDTH + 1) : ias_pkg::CFG_W;
   localparam int HCmpW = ($clog2(MAX_HEIGHT + 1) > ias_pkg::CFG_W) ?
                          $clog2(MAX_HEIGHT + 1) : ias_pkg::CFG_W;

   logic [ias_pkg::CFG_W-1:0]      frame_width_ff, frame_height_ff;
   logic [ColW-1:0]                col_ff, col_in;
   logic [RowW-1:0]                row_ff, row_in;
   logic [WCmpW-1:0]               width_eff, width_raw;
   logic [HCmpW-1:0]               height_eff, height_raw;
   logic                           row_end, frame_end, accept;

   logic                           s1_valid_ff, s1_valid_in, s1_adv;
   logic [ias_pkg::PIX_W-1:0]      s1_pixel_ff;
   logic [ColW-1:0]                s1_addr_ff;
   logic                           s1_first_row_ff, s1_first_col_ff, s1_frame_end_ff;
   logic                           fwd_ff, fwd_in;
   logic [ias_pkg::STORE_W-1:0]    fwd_data_ff;

   logic [ias_pkg::STORE_W-1:0]    ram_rdata, stored, wdata;
   logic [ias_pkg::PIX_SQ_W-1:0]   pix_sq;
   logic [ias_pkg::COL_SUM_W-1:0]  csum;
   logic [ias_pkg::COL_SQ_W-1:0]   csq;
   logic [ias_pkg::INT_W-1:0]      isum, left_sum_ff, left_sum_in;
   logic [ias_pkg::SQ_STATE_W-1:0] isq, left_sq_ff, left_sq_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ias_pkg::INT_W-1:0]      rsp_sum_ff;
   logic [ias_pkg::SQ_OUT_W-1:0]   rsp_sq_ff;
   logic                           rsp_frame_end_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= ias_pkg::CFG_W'(1024);
         frame_height_ff <= ias_pkg::CFG_W'(1024);
      end else if (csr_write_enable) begin
         unique case (ias_pkg::csr_index_type'(csr_index))
            ias_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            ias_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_raw  = WCmpW'(frame_width_ff);
      height_raw = HCmpW'(frame_height_ff);
      if (width_raw == '0) begin
         width_eff = WCmpW'(1);
      end else if (width_raw > WCmpW'(MAX_WIDTH)) begin
         width_eff = WCmpW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (height_raw == '0) begin
         height_eff = HCmpW'(1);
      end else if (height_raw > HCmpW'(MAX_HEIGHT)) begin
         height_eff = HCmpW'(MAX_HEIGHT);
      end else begin
         height_eff = height_raw;
      end
   end

   // handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // position
   assign row_end   = (WCmpW'(col_ff) + WCmpW'(1)) >= width_eff;
   assign frame_end = row_end && ((HCmpW'(row_ff) + HCmpW'(1)) >= height_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + RowW'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign fwd_in      = s1_adv && (s1_addr_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff     <= req_pixel;
         s1_addr_ff      <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_first_col_ff <= (col_ff == '0);
         s1_frame_end_ff <= frame_end;
         fwd_ff          <= fwd_in;
         fwd_data_ff     <= wdata;
      end
   end

   // line store
   ias_ram #(
      .WIDTH (ias_pkg::STORE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_addr_ff),
      .wdata (wdata),
      .re    (accept),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   // accumulate
   always_comb begin
      stored = fwd_ff ? fwd_data_ff : ram_rdata;
      pix_sq = ias_pkg::PIX_SQ_W'(s1_pixel_ff) * ias_pkg::PIX_SQ_W'(s1_pixel_ff);
      if (s1_first_row_ff) begin
         csum = ias_pkg::COL_SUM_W'(s1_pixel_ff);
         csq  = ias_pkg::COL_SQ_W'(pix_sq);
      end else begin
         csum = stored[ias_pkg::COL_SUM_W-1:0] + ias_pkg::COL_SUM_W'(s1_pixel_ff);
         csq  = stored[ias_pkg::STORE_W-1:ias_pkg::COL_SUM_W] + ias_pkg::COL_SQ_W'(pix_sq);
      end
      wdata = {csq, csum};
      isum  = (s1_first_col_ff ? '0 : left_sum_ff) + ias_pkg::INT_W'(csum);
      isq   = (s1_first_col_ff ? '0 : left_sq_ff) + ias_pkg::SQ_STATE_W'(csq);
      left_sum_in  = s1_adv ? isum : left_sum_ff;
      left_sq_in   = s1_adv ? isq : left_sq_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_sum_ff  <= '0;
         left_sq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_sum_ff  <= left_sum_in;
         left_sq_ff   <= left_sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold result until the transaction completes
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_sum_ff       <= isum;
         rsp_sq_ff        <= isq[ias_pkg::SQ_OUT_W-1:0];
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_integral_sum = rsp_sum_ff;
   assign rsp_square_sum   = rsp_sq_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

   `IAS_ASSERT_NXT(a_frame_wrap, clock, reset, accept && frame_end,
                   col_ff == '0 && row_ff == '0)
   `IAS_ASSERT_NXT(a_row_advance, clock, reset, accept && row_end && !frame_end,
                   col_ff == '0 && row_ff == $past(row_ff) + RowW'(1))
   `IAS_ASSERT_NXT(a_stage_hold, clock, reset, s1_valid_ff && !s1_adv,
                   s1_valid_ff && $stable(s1_addr_ff) && $stable(s1_pixel_ff))
   `IAS_ASSERT_IMP(a_no_accept_on_stall, clock, reset, s1_valid_ff && !s1_adv,
                   !req_ready)
endmodule

/* rtl/ias_ram.sv */
// Generic single-port-write, registered-read RAM
module ias_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the integral and squared integral image block
module tb_top;
   localparam int MAX_COLUMNS      = 1024;
   localparam int MAX_ROWS         = 1024;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PIXELS    = 420;
   localparam int WIDE_ROW_PIXELS  = 60;

   typedef enum {PIX_RANDOM, PIX_FULL, PIX_ZERO, PIX_MIXED} pixel_style_type;

   typedef struct packed {
      logic [ias_pkg::INT_W-1:0]    integral_sum;
      logic [ias_pkg::SQ_OUT_W-1:0] square_sum;
      logic                         frame_end;
   } sums_type;

   class integral_scoreboard;
      logic [ias_pkg::COL_SUM_W-1:0]  column_sums [MAX_COLUMNS];
      logic [ias_pkg::COL_SQ_W-1:0]   column_squares [MAX_COLUMNS];
      bit                             column_written [MAX_COLUMNS];
      logic [ias_pkg::INT_W-1:0]      left_sum;
      logic [ias_pkg::SQ_STATE_W-1:0] left_square;
      int unsigned                    column;
      int unsigned                    row;
      logic [ias_pkg::CFG_W-1:0]      width_reg;
      logic [ias_pkg::CFG_W-1:0]      height_reg;
      sums_type                       pending_sums [$];
      int                             failures;

      function new();
         left_sum    = '0;
         left_square = '0;
         column      = 0;
         row         = 0;
         width_reg   = ias_pkg::CFG_W'(1024);
         height_reg  = ias_pkg::CFG_W'(1024);
         failures    = 0;
         foreach (column_written[i]) column_written[i] = 1'b0;
      endfunction

      function int unsigned in_use(logic [ias_pkg::CFG_W-1:0] value, int unsigned limit);
         if (value == 0) return 1;
         if (value > limit) return limit;
         return 32'(value);
      endfunction

      function void set_register(ias_pkg::csr_index_type idx,
                                 logic [ias_pkg::CFG_W-1:0] value);
         unique case (idx)
            ias_pkg::CSR_FRAME_WIDTH: begin
               width_reg = value;
            end
            ias_pkg::CSR_FRAME_HEIGHT: begin
               height_reg = value;
            end
         endcase
      endfunction

      // a wider row below the top one must only read columns already written
      function bit columns_ready(logic [ias_pkg::CFG_W-1:0] value);
         int unsigned n;
         n = in_use(value, MAX_COLUMNS);
         if (row == 0) return 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!column_written[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_pixel(logic [ias_pkg::PIX_W-1:0] pixel);
         int unsigned                   w;
         int unsigned                   h;
         int unsigned                   addr;
         logic [ias_pkg::PIX_SQ_W-1:0]  pixel_sq;
         logic [ias_pkg::COL_SUM_W-1:0] col_sum;
         logic [ias_pkg::COL_SQ_W-1:0]  col_sq;
         logic                          row_end;
         sums_type                      due;
         w        = in_use(width_reg, MAX_COLUMNS);
         h        = in_use(height_reg, MAX_ROWS);
         pixel_sq = ias_pkg::PIX_SQ_W'(pixel) * ias_pkg::PIX_SQ_W'(pixel);
         addr     = (column < MAX_COLUMNS) ? column : MAX_COLUMNS - 1;
         if (column == 0) begin
            left_sum    = '0;
            left_square = '0;
         end
         if (row == 0) begin
            col_sum = ias_pkg::COL_SUM_W'(pixel);
            col_sq  = ias_pkg::COL_SQ_W'(pixel_sq);
         end else begin
            col_sum = column_sums[addr] + ias_pkg::COL_SUM_W'(pixel);
            col_sq  = column_squares[addr] + ias_pkg::COL_SQ_W'(pixel_sq);
         end
         column_sums[addr]    = col_sum;
         column_squares[addr] = col_sq;
         column_written[addr] = 1'b1;
         left_sum    = left_sum + ias_pkg::INT_W'(col_sum);
         left_square = left_square + ias_pkg::SQ_STATE_W'(col_sq);
         due.integral_sum = left_sum;
         due.square_sum   = left_square[ias_pkg::SQ_OUT_W-1:0];
         row_end          = (column + 1) >= w;
         due.frame_end    = row_end && ((row + 1) >= h);
         if (row_end) begin
            column = 0;
            row    = due.frame_end ? 0 : row + 1;
         end else begin
            column = column + 1;
         end
         if (due.frame_end) begin
            left_sum    = '0;
            left_square = '0;
         end
         pending_sums.push_back(due);
      endfunction

      function void check_result(logic [ias_pkg::INT_W-1:0] integral_sum,
                                 logic [ias_pkg::SQ_OUT_W-1:0] square_sum,
                                 logic frame_end);
         sums_type due;
         if (pending_sums.size() == 0) begin
            $error("result transaction with no pixel pending");
            failures++;
            return;
         end
         due = pending_sums.pop_front();
         if (integral_sum !== due.integral_sum) begin
            $error("integral_sum: expected %0d, got %0d", due.integral_sum, integral_sum);
            failures++;
         end
         if (square_sum !== due.square_sum) begin
            $error("square_sum: expected %0d, got %0d", due.square_sum, square_sum);
            failures++;
         end
         if (frame_end !== due.frame_end) begin
            $error("frame_end: expected %0d, got %0d", due.frame_end, frame_end);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_sums.size();
      endfunction
   endclass

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [ias_pkg::PIX_W-1:0]     req_pixel        = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic [ias_pkg::INT_W-1:0]     rsp_integral_sum;
   logic [ias_pkg::SQ_OUT_W-1:0]  rsp_square_sum;
   logic                          rsp_frame_end;
   logic                          csr_write_enable = 1'b0;
   logic [ias_pkg::CSR_IDX_W-1:0] csr_index        = '0;
   logic [ias_pkg::CFG_W-1:0]     csr_wdata        = '0;

   bit                   steady       = 1'b0;
   bit                   hold_results = 1'b0;
   integral_scoreboard   board        = new();

   integral_and_square_integral_image #(
      .MAX_WIDTH  (MAX_COLUMNS),
      .MAX_HEIGHT (MAX_ROWS)
   ) dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_pixel,
      .rsp_valid,
      .rsp_ready,
      .rsp_integral_sum,
      .rsp_square_sum,
      .rsp_frame_end,
      .csr_write_enable,
      .csr_index,
      .csr_wdata
   );

   always #10 clock = ~clock;

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic send_pixel(logic [ias_pkg::PIX_W-1:0] pixel);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(pixel);
   endtask

   task automatic await_results();
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(logic [ias_pkg::CFG_W-1:0] width_value,
                                  logic [ias_pkg::CFG_W-1:0] height_value);
      csr_write_enable <= 1'b1;
      csr_index        <= ias_pkg::CSR_FRAME_WIDTH;
      csr_wdata        <= width_value;
      @(posedge clock);
      board.set_register(ias_pkg::CSR_FRAME_WIDTH, width_value);
      csr_index <= ias_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= height_value;
      @(posedge clock);
      board.set_register(ias_pkg::CSR_FRAME_HEIGHT, height_value);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_geometry(logic [ias_pkg::CFG_W-1:0] width_value,
                               logic [ias_pkg::CFG_W-1:0] height_value);
      if (!board.columns_ready(width_value)) begin
         // close the frame with a single pixel at one by one
         write_registers(ias_pkg::CFG_W'(1), ias_pkg::CFG_W'(1));
         send_pixel(ias_pkg::PIX_W'($urandom_range(0, 255)));
         req_valid <= 1'b0;
         await_results();
      end
      write_registers(width_value, height_value);
   endtask

   task automatic push_pixels(int count, pixel_style_type style);
      logic [ias_pkg::PIX_W-1:0] pixel;
      for (int i = 0; i < count; i++) begin
         case (style)
            PIX_FULL: begin
               pixel = '1;
            end
            PIX_ZERO: begin
               pixel = '0;
            end
            PIX_MIXED: begin
               pixel = i[0] ? '0 : '1;
            end
            default: begin
               pixel = ias_pkg::PIX_W'($urandom_range(0, 255));
               if ($urandom_range(0, 7) == 0) pixel = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
         send_pixel(pixel);
      end
      req_valid <= 1'b0;
      await_results();
   endtask

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (hold_results) begin
            stall        = LONG_HOLD_CYCLES;
            hold_results = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result(rsp_integral_sum, rsp_square_sum, rsp_frame_end);
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int                        random_pixels;
      int                        phase;
      int                        count;
      logic [ias_pkg::CFG_W-1:0] width_value;
      logic [ias_pkg::CFG_W-1:0] height_value;
      random_pixels = 0;
      phase         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_pixels(4, PIX_MIXED);
      // shrink the width mid-row: the current column ends its row
      set_geometry(ias_pkg::CFG_W'(0), ias_pkg::CFG_W'(2047));
      push_pixels(3, PIX_FULL);
      set_geometry(ias_pkg::CFG_W'(2), ias_pkg::CFG_W'(0));
      push_pixels(4, PIX_MIXED);
      set_geometry(ias_pkg::CFG_W'(3), ias_pkg::CFG_W'(3));
      push_pixels(9, PIX_FULL);
      // narrow, then widen mid-frame so columns from the previous frame are read as they stand
      set_geometry(ias_pkg::CFG_W'(1), ias_pkg::CFG_W'(3));
      push_pixels(2, PIX_RANDOM);
      set_geometry(ias_pkg::CFG_W'(3), ias_pkg::CFG_W'(3));
      push_pixels(3, PIX_FULL);
      set_geometry(ias_pkg::CFG_W'(2047), ias_pkg::CFG_W'(1));
      push_pixels(WIDE_ROW_PIXELS, PIX_RANDOM);

      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: width_value = ias_pkg::CFG_W'($urandom_range(1, 8));
            6:       width_value = '0;
            7:       width_value = $urandom_range(0, 1) ? ias_pkg::CFG_W'(2047) :
                                                          ias_pkg::CFG_W'(1024);
            8:       width_value = ias_pkg::CFG_W'($urandom_range(0, 2047));
            default: width_value = ias_pkg::CFG_W'($urandom_range(9, 40));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: height_value = ias_pkg::CFG_W'($urandom_range(1, 6));
            7:       height_value = '0;
            8:       height_value = ias_pkg::CFG_W'(2047);
            default: height_value = ias_pkg::CFG_W'($urandom_range(7, 1024));
         endcase
         count  = $urandom_range(1, 40);
         steady = ($urandom_range(0, 3) == 0);
         set_geometry(width_value, height_value);
         if (phase == 3) begin
            // back-pressure: hold results long enough to fill the block
            steady       = 1'b1;
            hold_results = 1'b1;
            count        = 80;
         end
         push_pixels(count, pixel_style_type'($urandom_range(0, 3)));
         random_pixels += count;
         phase++;
      end

      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/ias_pkg.sv
rtl/ias_ram.sv
rtl/integral_and_square_integral_image.sv
verif/tb_top.sv
